// ===== hw/rtl/lcmh_pkg.sv =====
`default_nettype none
package lcmh_pkg;

    localparam int HEAP_CAPACITY = 64;
    localparam int ID_SPACE      = 256;
    localparam int COUNT_WIDTH   = 20;

    localparam int SLOT_W  = $clog2(HEAP_CAPACITY);
    localparam int OCC_W   = $clog2(HEAP_CAPACITY + 1);
    localparam int ID_W    = 8;
    localparam int ENTRY_W = COUNT_WIDTH + ID_W;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_ADJUST = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_QUERY  = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_ADJUST,
        OP_REMOVE,
        OP_QUERY,
        OP_CLEAR,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  id;
        logic [19:0] cnt;
        logic [31:0] ip;
        logic [15:0] sport;
        logic [15:0] lport;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] key;
        logic [ID_W-1:0]        id;
    } entry_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DISPATCH,
        BK_RD_LAST,
        BK_DN_RD,
        BK_DN_CMP,
        BK_UP_RD,
        BK_UP_CMP,
        BK_PLACE,
        BK_PAY_RD,
        BK_RESULT
    } bk_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lcmh_front.sv =====
`default_nettype none
module lcmh_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [2:0]    s_req_type,
    input  wire logic [7:0]    s_server_id,
    input  wire logic [19:0]   s_con_count,
    input  wire logic [31:0]   s_ip_addr,
    input  wire logic [15:0]   s_service_port,
    input  wire logic [15:0]   s_listen_port,
    output logic               cmd_avail,
    output lcmh_pkg::cmd_t     cmd_head,
    input  wire logic          cmd_pop
);

    lcmh_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     fill_reg;
    lcmh_pkg::cmd_t in_cmd;
    logic           push;

    // classify request type
    always_comb begin
        unique case (s_req_type)
            lcmh_pkg::REQ_INSERT: in_cmd.op = lcmh_pkg::OP_INSERT;
            lcmh_pkg::REQ_ADJUST: in_cmd.op = lcmh_pkg::OP_ADJUST;
            lcmh_pkg::REQ_REMOVE: in_cmd.op = lcmh_pkg::OP_REMOVE;
            lcmh_pkg::REQ_QUERY:  in_cmd.op = lcmh_pkg::OP_QUERY;
            lcmh_pkg::REQ_CLEAR:  in_cmd.op = lcmh_pkg::OP_CLEAR;
            default:              in_cmd.op = lcmh_pkg::OP_BAD;
        endcase
        in_cmd.id    = s_server_id;
        in_cmd.cnt   = s_con_count;
        in_cmd.ip    = s_ip_addr;
        in_cmd.sport = s_service_port;
        in_cmd.lport = s_listen_port;
    end

    assign s_ready   = (fill_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_avail = (fill_reg != 2'd0);
    assign cmd_head  = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (cmd_pop) rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lcmh_back.sv =====
`default_nettype none
module lcmh_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_avail,
    input  wire lcmh_pkg::cmd_t cmd_head,
    output logic               cmd_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_status,
    output logic               m_min_valid,
    output logic [7:0]         m_min_server_id,
    output logic [19:0]        m_min_con_count,
    output logic [31:0]        m_min_ip_addr,
    output logic [15:0]        m_min_service_port,
    output logic [15:0]        m_min_listen_port,
    output logic [6:0]         m_heap_count
);

    localparam int SW = lcmh_pkg::SLOT_W;
    localparam int OW = lcmh_pkg::OCC_W;

    // storage
    lcmh_pkg::entry_t heap_mem [lcmh_pkg::HEAP_CAPACITY];
    logic [SW-1:0]    pos_mem  [lcmh_pkg::ID_SPACE];
    logic [63:0]      pay_mem  [lcmh_pkg::ID_SPACE];
    logic [lcmh_pkg::ID_SPACE-1:0] vld_reg, vld_next;

    lcmh_pkg::entry_t heap_rda_q, heap_rdb_q;
    logic [SW-1:0]    pos_rd_q;
    logic [63:0]      pay_rd_q;

    logic [SW-1:0]    heap_ra, heap_rb, heap_wa, pos_wa;
    logic             heap_we, pos_we, pay_we;
    lcmh_pkg::entry_t heap_wd;
    logic [7:0]       pos_ra, pos_wid, pay_ra;
    logic [SW-1:0]    pos_wd;

    lcmh_pkg::bk_state_t state_reg, state_next;
    lcmh_pkg::cmd_t   cmd_reg, cmd_next;
    lcmh_pkg::entry_t cur_reg, cur_next, root_reg, root_next;
    logic [SW-1:0]    idx_reg, idx_next;
    logic [OW-1:0]    lim_reg, lim_next, occ_reg, occ_next;
    logic             moved_reg, moved_next;
    logic [1:0]       status_reg, status_next;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]   o_status_reg;
    logic         o_min_valid_reg;
    logic [7:0]   o_id_reg;
    logic [19:0]  o_cnt_reg;
    logic [31:0]  o_ip_reg;
    logic [15:0]  o_sp_reg, o_lp_reg;
    logic [6:0]   o_count_reg;
    logic         load_out;

    logic          present;
    logic [OW-1:0] last_slot;
    logic [SW:0]   child_a;
    logic [SW+1:0] child_b;
    logic          pick_b;
    lcmh_pkg::entry_t child;
    logic [SW-1:0] parent_idx;

    always_ff @(posedge aclk) begin
        heap_rda_q <= heap_mem[heap_ra];
        heap_rdb_q <= heap_mem[heap_rb];
        if (heap_we) heap_mem[heap_wa] <= heap_wd;
    end

    always_ff @(posedge aclk) begin
        pos_rd_q <= pos_mem[pos_ra];
        if (pos_we) pos_mem[pos_wid] <= pos_wd;
    end

    always_ff @(posedge aclk) begin
        pay_rd_q <= pay_mem[pay_ra];
        if (pay_we) pay_mem[cmd_reg.id] <= {cmd_reg.ip, cmd_reg.sport, cmd_reg.lport};
    end

    assign present   = vld_reg[cmd_reg.id] && ({1'b0, pos_rd_q} < occ_reg);
    assign last_slot = occ_reg - OW'(1);
    assign child_a   = {idx_reg, 1'b1};
    assign child_b   = {1'b0, child_a} + (SW+2)'(1);
    assign pick_b    = (child_b < {1'b0, lim_reg}) && (heap_rdb_q.key < heap_rda_q.key);
    assign child     = pick_b ? heap_rdb_q : heap_rda_q;
    assign parent_idx = SW'((idx_reg - SW'(1)) >> 1);
    assign load_out  = !out_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        occ_next    = occ_reg;
        moved_next  = moved_reg;
        status_next = status_reg;
        vld_next    = vld_reg;
        cmd_pop     = 1'b0;
        heap_ra     = SW'(last_slot);
        heap_rb     = SW'(0);
        heap_we     = 1'b0;
        heap_wa     = idx_reg;
        heap_wd     = cur_reg;
        pos_ra      = cmd_head.id;
        pos_we      = 1'b0;
        pos_wid     = cur_reg.id;
        pos_wd      = idx_reg;
        pay_we      = 1'b0;
        pay_ra      = root_reg.id;
        out_valid_next = out_valid_reg && !m_ready;

        unique case (state_reg)
            lcmh_pkg::BK_IDLE: begin
                if (cmd_avail) begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_head;
                    state_next = lcmh_pkg::BK_DISPATCH;
                end
            end
            lcmh_pkg::BK_DISPATCH: begin
                status_next = lcmh_pkg::ST_OK;
                cur_next    = '{key: cmd_reg.cnt, id: cmd_reg.id};
                idx_next    = pos_rd_q;
                lim_next    = occ_reg;
                moved_next  = 1'b0;
                state_next  = lcmh_pkg::BK_PAY_RD;
                unique case (cmd_reg.op)
                    lcmh_pkg::OP_BAD: status_next = lcmh_pkg::ST_BAD;
                    lcmh_pkg::OP_CLEAR: begin
                        vld_next = '0;
                        occ_next = '0;
                    end
                    lcmh_pkg::OP_QUERY: begin
                        if (occ_reg == '0) status_next = lcmh_pkg::ST_ABSENT;
                    end
                    lcmh_pkg::OP_INSERT: begin
                        if (present) begin
                            pay_we     = 1'b1;
                            state_next = lcmh_pkg::BK_DN_RD;
                        end else if (occ_reg >= OW'(lcmh_pkg::HEAP_CAPACITY)) begin
                            status_next = lcmh_pkg::ST_FULL;
                        end else begin
                            pay_we   = 1'b1;
                            vld_next[cmd_reg.id] = 1'b1;
                            idx_next = SW'(occ_reg);
                            occ_next = occ_reg + OW'(1);
                            state_next = lcmh_pkg::BK_UP_RD;
                        end
                    end
                    lcmh_pkg::OP_ADJUST: begin
                        if (present) state_next = lcmh_pkg::BK_DN_RD;
                        else status_next = lcmh_pkg::ST_ABSENT;
                    end
                    lcmh_pkg::OP_REMOVE: begin
                        if (present) begin
                            vld_next[cmd_reg.id] = 1'b0;
                            occ_next = last_slot;
                            lim_next = last_slot;
                            if ({1'b0, pos_rd_q} < last_slot) begin
                                state_next = lcmh_pkg::BK_RD_LAST;
                            end
                        end else begin
                            status_next = lcmh_pkg::ST_ABSENT;
                        end
                    end
                    default: status_next = lcmh_pkg::ST_BAD;
                endcase
            end
            lcmh_pkg::BK_RD_LAST: begin
                cur_next   = heap_rda_q;
                state_next = lcmh_pkg::BK_DN_RD;
            end
            lcmh_pkg::BK_DN_RD: begin
                heap_ra = SW'(child_a);
                heap_rb = SW'(child_b);
                if ({1'b0, child_a} >= {1'b0, lim_reg}) begin
                    state_next = moved_reg ? lcmh_pkg::BK_PLACE : lcmh_pkg::BK_UP_RD;
                end else begin
                    state_next = lcmh_pkg::BK_DN_CMP;
                end
            end
            lcmh_pkg::BK_DN_CMP: begin
                if (cur_reg.key < child.key) begin
                    state_next = moved_reg ? lcmh_pkg::BK_PLACE : lcmh_pkg::BK_UP_RD;
                end else begin
                    // pull the smaller child into the hole
                    heap_we    = 1'b1;
                    heap_wd    = child;
                    pos_we     = 1'b1;
                    pos_wid    = child.id;
                    idx_next   = pick_b ? SW'(child_b) : SW'(child_a);
                    moved_next = 1'b1;
                    state_next = lcmh_pkg::BK_DN_RD;
                end
            end
            lcmh_pkg::BK_UP_RD: begin
                heap_ra = parent_idx;
                state_next = (idx_reg == '0) ? lcmh_pkg::BK_PLACE : lcmh_pkg::BK_UP_CMP;
            end
            lcmh_pkg::BK_UP_CMP: begin
                heap_ra = parent_idx;
                if (heap_rda_q.key < cur_reg.key) begin
                    state_next = lcmh_pkg::BK_PLACE;
                end else begin
                    heap_we    = 1'b1;
                    heap_wd    = heap_rda_q;
                    pos_we     = 1'b1;
                    pos_wid    = heap_rda_q.id;
                    idx_next   = parent_idx;
                    state_next = lcmh_pkg::BK_UP_RD;
                end
            end
            lcmh_pkg::BK_PLACE: begin
                heap_we    = 1'b1;
                pos_we     = 1'b1;
                state_next = lcmh_pkg::BK_PAY_RD;
            end
            lcmh_pkg::BK_PAY_RD: begin
                state_next = lcmh_pkg::BK_RESULT;
            end
            lcmh_pkg::BK_RESULT: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    state_next     = lcmh_pkg::BK_IDLE;
                end
            end
            default: state_next = lcmh_pkg::BK_IDLE;
        endcase
    end

    assign root_next = (heap_we && heap_wa == '0) ? heap_wd : root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcmh_pkg::BK_IDLE;
            occ_reg       <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        idx_reg    <= idx_next;
        lim_reg    <= lim_next;
        moved_reg  <= moved_next;
        status_reg <= status_next;
        root_reg   <= root_next;
        if (state_reg == lcmh_pkg::BK_RESULT && load_out) begin
            o_status_reg    <= status_reg;
            o_min_valid_reg <= (occ_reg != '0);
            o_count_reg     <= 7'(occ_reg);
            if (occ_reg != '0) begin
                o_id_reg  <= root_reg.id;
                o_cnt_reg <= root_reg.key;
                o_ip_reg  <= pay_rd_q[63:32];
                o_sp_reg  <= pay_rd_q[31:16];
                o_lp_reg  <= pay_rd_q[15:0];
            end else begin
                o_id_reg  <= '0;
                o_cnt_reg <= '0;
                o_ip_reg  <= '0;
                o_sp_reg  <= '0;
                o_lp_reg  <= '0;
            end
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = o_status_reg;
    assign m_min_valid        = o_min_valid_reg;
    assign m_min_server_id    = o_id_reg;
    assign m_min_con_count    = o_cnt_reg;
    assign m_min_ip_addr      = o_ip_reg;
    assign m_min_service_port = o_sp_reg;
    assign m_min_listen_port  = o_lp_reg;
    assign m_heap_count       = o_count_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/least_connections_indexed_min_heap_core.sv =====
`default_nettype none
// Least-connections server selector built on an indexed binary min-heap.
// Input channel (s_*): one request per transaction: insert/update, adjust
// count, remove, query minimum or clear, with server id, count, address and
// ports. Output channel (m_*): exactly one result per request, in order,
// with status, the current minimum server and the heap size afterwards.
// A two-entry command queue sits in front of the heap engine, so requests
// are taken while the engine works or while a result waits on m_ready.
// Each request runs alone in the engine: a query, clear or rejected request
// passes the dispatch, payload-read and result states before m_valid, and
// the engine takes the next one only once that result is loaded. A sift
// walks the heap level by level, each level a registered heap-memory read,
// then compare and move, and ends by placing the entry. With 64 slots the
// heap is at most 6 levels deep. The heap slot memory and the server payload
// memory have one write port each; the read-compare-move loop sets the rate.
// Reset (aresetn low, synchronous) empties the heap, marks every position
// table entry invalid and drops queued requests and a pending result; no
// clearing pass is needed. When the receiver stalls, hold the result, park
// the engine on it and drop s_ready once the command queue has filled.
module least_connections_indexed_min_heap_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [7:0]  s_server_id,
    input  wire logic [19:0] s_con_count,
    input  wire logic [31:0] s_ip_addr,
    input  wire logic [15:0] s_service_port,
    input  wire logic [15:0] s_listen_port,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic             m_min_valid,
    output logic [7:0]       m_min_server_id,
    output logic [19:0]      m_min_con_count,
    output logic [31:0]      m_min_ip_addr,
    output logic [15:0]      m_min_service_port,
    output logic [15:0]      m_min_listen_port,
    output logic [6:0]       m_heap_count
);

    logic           cmd_avail;
    logic           cmd_pop;
    lcmh_pkg::cmd_t cmd_head;

    // front: accept and classify transactions into the command queue
    lcmh_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_server_id    (s_server_id),
        .s_con_count    (s_con_count),
        .s_ip_addr      (s_ip_addr),
        .s_service_port (s_service_port),
        .s_listen_port  (s_listen_port),
        .cmd_avail      (cmd_avail),
        .cmd_head       (cmd_head),
        .cmd_pop        (cmd_pop)
    );

    // back: heap engine and result register
    lcmh_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd_avail          (cmd_avail),
        .cmd_head           (cmd_head),
        .cmd_pop            (cmd_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_min_valid        (m_min_valid),
        .m_min_server_id    (m_min_server_id),
        .m_min_con_count    (m_min_con_count),
        .m_min_ip_addr      (m_min_ip_addr),
        .m_min_service_port (m_min_service_port),
        .m_min_listen_port  (m_min_listen_port),
        .m_heap_count       (m_heap_count)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/lcmh_checker.sv =====
`default_nettype none
module lcmh_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic        m_min_valid,
    input wire logic [7:0]  m_min_server_id,
    input wire logic [19:0] m_min_con_count,
    input wire logic [6:0]  m_heap_count
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");

    a_min_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_min_valid == (m_heap_count != 7'd0)))
        else $error("min_valid disagrees with heap count");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_min_valid |-> m_min_server_id == 8'd0 && m_min_con_count == 20'd0)
        else $error("empty heap reports a server");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind least_connections_indexed_min_heap_core lcmh_checker u_lcmh_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_min_valid     (m_min_valid),
    .m_min_server_id (m_min_server_id),
    .m_min_con_count (m_min_con_count),
    .m_heap_count    (m_heap_count)
);
`default_nettype wire
